FILE: design/xcpd_pkg.sv
// Package for the packet deframer: widths, register indexes and the
// controller/datapath command and status structures. No dependencies.
`timescale 1ns / 1ps
package xcpd_pkg;
    localparam int RING_DEPTH_DEF = 64;
    localparam int FRAME_OVERHEAD = 7;
    localparam int OFS_LEN = 5;
    localparam int OFS_PAYLOAD = 6;
    localparam int HEADER_SKIP = 2;
    localparam logic [7:0] HDR_FIRST_RST = 8'd170;
    localparam logic [7:0] HDR_SECOND_RST = 8'd85;
    localparam logic [0:0] REG_HDR_FIRST = 1'b0;
    localparam logic [0:0] REG_HDR_SECOND = 1'b1;

    typedef enum logic [2:0] {
        PEEK_NONE = 3'd0,
        PEEK_BASE = 3'd1,
        PEEK_HDR = 3'd2
    } peek_mode_t;

    typedef struct packed {
        logic        write_byte;
        logic        rd_req;
        logic [10:0] rd_off;
        logic        adv;
        logic [9:0]  adv_n;
    } dp_cmd_t;

    typedef struct packed {
        logic [10:0] unread;
        logic [7:0]  rd_data;
    } dp_stat_t;
endpackage

FILE: design/xor_checked_packet_deframer_core.sv
// Sequential packet deframer with header scan and XOR check.
// Steps per item: accept the byte, start each scan, read ring bytes (issue, wait,
// use), emit each payload byte, then finish.
// Input: one rx_byte per parse pass; in_stall is high for the
// whole pass and a stalled output holds it. The single ring read port sets the pace.
// Reset: rst_n clears positions, state and registers to 170 and 85.
`timescale 1ns / 1ps
module xor_checked_packet_deframer_core #(
    parameter int RING_DEPTH = xcpd_pkg::RING_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:2]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  pkg_id,
    output logic [7:0]  remain,
    output logic [7:0]  cmd,
    output logic [7:0]  data_len,
    output logic [7:0]  data_index,
    output logic [7:0]  data_byte,
    output logic        has_data,
    output logic        packet_end,
    output logic        last
);
    import xcpd_pkg::*;
    logic [7:0] hf_reg, hs_reg;
    dp_cmd_t  c;
    dp_stat_t s;

    assign pready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hf_reg <= HDR_FIRST_RST;
            hs_reg <= HDR_SECOND_RST;
        end
        else if (psel && penable && pwrite)
        begin
            if (paddr[2] == REG_HDR_FIRST)
                hf_reg <= pwdata[7:0];
            else
                hs_reg <= pwdata[7:0];
        end
    end
    assign prdata = {24'd0, (paddr[2] == REG_HDR_FIRST) ? hf_reg : hs_reg};

    xcpd_datapath #(.RING_DEPTH(RING_DEPTH)) u_dp (
        .clk(clk), .rst_n(rst_n), .wr_byte(rx_byte), .cmd_in(c), .stat(s));

    xcpd_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .hdr_first(hf_reg), .hdr_second(hs_reg), .stat(s), .cmd_out(c),
        .out_valid(out_valid), .out_stall(out_stall), .pkg_id(pkg_id),
        .remain(remain), .cmd(cmd), .data_len(data_len),
        .data_index(data_index), .data_byte(data_byte), .has_data(has_data),
        .packet_end(packet_end), .last(last));
endmodule

FILE: design/xcpd_datapath.sv
// Datapath of the packet deframer: ring memory, write and read positions.
// Depends on xcpd_pkg; driven by xcpd_ctrl through command signals.
`timescale 1ns / 1ps
module xcpd_datapath #(
    parameter int RING_DEPTH = xcpd_pkg::RING_DEPTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [7:0]        wr_byte,
    input  xcpd_pkg::dp_cmd_t cmd_in,
    output xcpd_pkg::dp_stat_t stat
);
    import xcpd_pkg::*;
    localparam int AW = $clog2(RING_DEPTH);
    localparam logic [AW:0] DEPTH_W = (AW + 1)'(RING_DEPTH);

    logic [7:0]    mem [RING_DEPTH];
    logic [AW-1:0] wp_reg, rp_reg, wp_next, rp_next;
    logic [7:0]    rd_reg;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wp_inc;
    logic [AW:0]   diff;

    // Both operands are below the ring depth, so one subtraction wraps the sum.
    function automatic logic [AW-1:0] ring_add(logic [AW-1:0] a, logic [AW-1:0] b);
        logic [AW:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        if (sum >= DEPTH_W)
            sum = sum - DEPTH_W;
        return sum[AW-1:0];
    endfunction

    assign wp_inc = ring_add(wp_reg, AW'(1));
    assign rd_addr = ring_add(rp_reg, cmd_in.rd_off[AW-1:0]);

    always_comb
    begin
        wp_next = wp_reg;
        rp_next = rp_reg;
        if (cmd_in.write_byte)
        begin
            wp_next = wp_inc;
            if (wp_inc == rp_reg)
                rp_next = ring_add(rp_reg, AW'(1));
        end
        else if (cmd_in.adv)
        begin
            rp_next = ring_add(rp_reg, cmd_in.adv_n[AW-1:0]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0;
            rp_reg <= '0;
        end
        else
        begin
            wp_reg <= wp_next;
            rp_reg <= rp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_in.write_byte)
            mem[wp_reg] <= wr_byte;
        if (cmd_in.rd_req)
            rd_reg <= mem[rd_addr];
    end

    assign diff = ({1'b0, wp_reg} >= {1'b0, rp_reg})
                  ? ({1'b0, wp_reg} - {1'b0, rp_reg})
                  : ({1'b0, wp_reg} + DEPTH_W - {1'b0, rp_reg});
    assign stat.unread = 11'(diff);
    assign stat.rd_data = rd_reg;
endmodule

FILE: design/xcpd_ctrl.sv
// Controller of the packet deframer: scans for the header, checks the XOR
// and emits results. Depends on xcpd_pkg; commands xcpd_datapath.
`timescale 1ns / 1ps
module xcpd_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [7:0]         hdr_first,
    input  logic [7:0]         hdr_second,
    input  xcpd_pkg::dp_stat_t stat,
    output xcpd_pkg::dp_cmd_t  cmd_out,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [7:0]         pkg_id,
    output logic [7:0]         remain,
    output logic [7:0]         cmd,
    output logic [7:0]         data_len,
    output logic [7:0]         data_index,
    output logic [7:0]         data_byte,
    output logic               has_data,
    output logic               packet_end,
    output logic               last
);
    import xcpd_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_SCAN  = 9'b000000010,
        S_RD    = 9'b000000100,
        S_WAIT  = 9'b000001000,
        S_EVAL  = 9'b000010000,
        S_SUM   = 9'b000100000,
        S_EMIT  = 9'b001000000,
        S_OUT   = 9'b010000000,
        S_LAST  = 9'b100000000
    } state_t;

    state_t      st_reg, st_next;
    logic [10:0] off_reg, off_next;
    logic [7:0]  b0_reg, b0_next;
    logic [7:0]  sum_reg, sum_next;
    logic [7:0]  len_reg, len_next;
    logic [7:0]  id_reg, id_next, rem_reg, rem_next, cmd_reg, cmd_next;
    logic [7:0]  idx_reg, idx_next;
    logic        pend_reg, pend_next;
    logic        ov_reg, ov_next;
    logic [7:0]  obyte_reg, obyte_next;
    logic        ohas_reg, ohas_next, oend_reg, oend_next, olast_reg, olast_next;
    logic [10:0] plen;
    logic [7:0]  p_id_reg, p_rem_reg, p_cmd_reg, p_len_reg, p_idx_reg, p_byte_reg;
    logic        p_has_reg, p_end_reg;
    logic        load_out;
    logic [7:0]  o_id_reg, o_rem_reg, o_cmd_reg, o_len_reg, o_idx_reg, o_byte_reg;
    logic        o_has_reg, o_end_reg;

    assign plen = 11'(len_reg) + 11'(FRAME_OVERHEAD);
    assign in_stall = (st_reg != S_IDLE);
    assign out_valid = ov_reg;
    assign pkg_id = o_id_reg;
    assign remain = o_rem_reg;
    assign cmd = o_cmd_reg;
    assign data_len = o_len_reg;
    assign data_index = o_idx_reg;
    assign data_byte = o_byte_reg;
    assign has_data = o_has_reg;
    assign packet_end = o_end_reg;
    assign last = olast_reg;

    // Phases of the read pipeline: S_RD issues an offset, S_WAIT lets the
    // registered read return, S_EVAL uses it.
    always_comb
    begin
        st_next = st_reg;
        off_next = off_reg;
        b0_next = b0_reg;
        sum_next = sum_reg;
        len_next = len_reg;
        id_next = id_reg;
        rem_next = rem_reg;
        cmd_next = cmd_reg;
        idx_next = idx_reg;
        pend_next = pend_reg;
        ov_next = ov_reg;
        obyte_next = obyte_reg;
        ohas_next = ohas_reg;
        oend_next = oend_reg;
        olast_next = olast_reg;
        cmd_out = '0;
        if (ov_reg && !out_stall)
            ov_next = 1'b0;
        case (st_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_out.write_byte = 1'b1;
                    pend_next = 1'b0;
                    st_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (stat.unread < 11'd2)
                    st_next = S_LAST;
                else
                begin
                    off_next = '0;
                    sum_next = '0;
                    st_next = S_RD;
                end
            end
            S_RD:
            begin
                cmd_out.rd_req = 1'b1;
                cmd_out.rd_off = off_reg;
                st_next = S_WAIT;
            end
            S_WAIT:
            begin
                st_next = S_EVAL;
            end
            S_EVAL:
            begin
                off_next = off_reg + 11'd1;
                st_next = S_RD;
                sum_next = sum_reg ^ stat.rd_data;
                if (off_reg == 11'd0)
                    b0_next = stat.rd_data;
                else if (off_reg == 11'd1)
                begin
                    if (!(b0_reg == hdr_first && stat.rd_data == hdr_second))
                    begin
                        cmd_out.adv = 1'b1;
                        cmd_out.adv_n = 10'd1;
                        st_next = S_SCAN;
                    end
                    else if (stat.unread < 11'(FRAME_OVERHEAD))
                        st_next = S_LAST;
                end
                else if (off_reg == 11'd2)
                    id_next = stat.rd_data;
                else if (off_reg == 11'd3)
                    rem_next = stat.rd_data;
                else if (off_reg == 11'd4)
                    cmd_next = stat.rd_data;
                else if (off_reg == 11'd5)
                begin
                    len_next = stat.rd_data;
                    if (stat.unread < 11'(stat.rd_data) + 11'(FRAME_OVERHEAD))
                        st_next = S_LAST;
                end
                else if (off_reg == 11'(len_reg) + 11'(OFS_PAYLOAD))
                begin
                    sum_next = sum_reg;
                    st_next = S_SUM;
                    if (sum_reg != stat.rd_data)
                    begin
                        cmd_out.adv = 1'b1;
                        cmd_out.adv_n = 10'(HEADER_SKIP);
                        st_next = S_SCAN;
                    end
                    else
                    begin
                        idx_next = '0;
                        off_next = 11'(OFS_PAYLOAD);
                    end
                end
            end
            S_SUM:
            begin
                if (len_reg == 8'd0)
                begin
                    st_next = S_OUT;
                    obyte_next = '0;
                    ohas_next = 1'b0;
                    oend_next = 1'b1;
                end
                else
                begin
                    cmd_out.rd_req = 1'b1;
                    cmd_out.rd_off = off_reg;
                    st_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                obyte_next = stat.rd_data;
                ohas_next = 1'b1;
                oend_next = (idx_reg + 8'd1 == len_reg);
                st_next = S_OUT;
            end
            S_OUT:
            begin
                // Hold the result until the output register is free.
                if (!ov_reg || !out_stall)
                begin
                    if (pend_reg)
                    begin
                        ov_next = 1'b1;
                        olast_next = 1'b0;
                    end
                    if (oend_reg)
                    begin
                        cmd_out.adv = 1'b1;
                        cmd_out.adv_n = 10'(plen);
                        pend_next = 1'b1;
                        st_next = S_SCAN;
                    end
                    else
                    begin
                        pend_next = 1'b1;
                        idx_next = idx_reg + 8'd1;
                        off_next = off_reg + 11'd1;
                        st_next = S_SUM;
                    end
                end
            end
            S_LAST:
            begin
                if (!ov_reg || !out_stall)
                begin
                    if (pend_reg)
                    begin
                        ov_next = 1'b1;
                        olast_next = 1'b1;
                    end
                    pend_next = 1'b0;
                    st_next = S_IDLE;
                end
            end
            default:
            begin
                st_next = S_IDLE;
            end
        endcase
    end

    // The pending slot holds the previous result so that the final one of a
    // byte can be marked last; output payload registers shift in from it.
    assign load_out = (st_reg == S_OUT || st_reg == S_LAST) && (!ov_reg || !out_stall)
                      && pend_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= S_IDLE;
            ov_reg <= 1'b0;
            pend_reg <= 1'b0;
        end
        else
        begin
            st_reg <= st_next;
            ov_reg <= ov_next;
            pend_reg <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        off_reg <= off_next;
        b0_reg <= b0_next;
        sum_reg <= sum_next;
        len_reg <= len_next;
        id_reg <= id_next;
        rem_reg <= rem_next;
        cmd_reg <= cmd_next;
        idx_reg <= idx_next;
        obyte_reg <= obyte_next;
        ohas_reg <= ohas_next;
        oend_reg <= oend_next;
        olast_reg <= olast_next;
        if (load_out)
        begin
            o_id_reg <= p_id_reg;
            o_rem_reg <= p_rem_reg;
            o_cmd_reg <= p_cmd_reg;
            o_len_reg <= p_len_reg;
            o_idx_reg <= p_idx_reg;
            o_byte_reg <= p_byte_reg;
            o_has_reg <= p_has_reg;
            o_end_reg <= p_end_reg;
        end
        if (st_reg == S_OUT && (!ov_reg || !out_stall))
        begin
            p_id_reg <= id_reg;
            p_rem_reg <= rem_reg;
            p_cmd_reg <= cmd_reg;
            p_len_reg <= len_reg;
            p_idx_reg <= idx_reg;
            p_byte_reg <= obyte_reg;
            p_has_reg <= ohas_reg;
            p_end_reg <= oend_reg;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && out_stall) |=> ov_reg)
        else $error("result dropped while stalled");
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd_out.write_byte |-> !cmd_out.adv)
        else $error("write and advance together");
    assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == S_IDLE) |-> !pend_reg)
        else $error("pending result left at idle");
endmodule

FILE: tb/xcpd_checker.sv
// Checker for the packet deframer: watches the register, byte and result channels,
// models the ring and the parser, and compares every result field by field.
// Depends on xcpd_pkg for the ring depth, frame constants, header resets and register indexes.
`timescale 1ns / 1ps
module xcpd_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:2]  paddr,
    input  logic [31:0] pwdata,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [7:0]  rx_byte,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [7:0]  pkg_id,
    input  logic [7:0]  remain,
    input  logic [7:0]  cmd,
    input  logic [7:0]  data_len,
    input  logic [7:0]  data_index,
    input  logic [7:0]  data_byte,
    input  logic        has_data,
    input  logic        packet_end,
    input  logic        last,
    output int          fail_count,
    output int          pending_count,
    output int          result_count
);
    import xcpd_pkg::*;

    localparam int DEPTH = RING_DEPTH_DEF;

    typedef struct packed {
        logic [7:0] id;
        logic [7:0] rem;
        logic [7:0] command;
        logic [7:0] len;
        logic [7:0] index;
        logic [7:0] value;
        logic       has;
        logic       pend;
        logic       fin;
    } frame_result_t;

    frame_result_t payload_queue[$];
    logic [7:0] ring[DEPTH];
    int unsigned wr_ptr;
    int unsigned rd_ptr;
    logic [7:0] sync_first;
    logic [7:0] sync_second;

    assign pending_count = payload_queue.size();

    function automatic logic [7:0] at(int unsigned off);
        return ring[(rd_ptr + off) % DEPTH];
    endfunction

    task automatic report(string what, logic [7:0] got, logic [7:0] want);
        $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
        fail_count++;
    endtask

    task automatic deframe_byte(logic [7:0] b);
        int unsigned u;
        int unsigned len;
        int first;
        logic [7:0] sum;
        frame_result_t r;
        first = payload_queue.size();
        ring[wr_ptr] = b;
        wr_ptr = (wr_ptr + 1) % DEPTH;
        if (wr_ptr == rd_ptr)
            rd_ptr = (rd_ptr + 1) % DEPTH;
        forever
        begin
            u = (wr_ptr + DEPTH - rd_ptr) % DEPTH;
            while (u >= 2 && !(at(0) == sync_first && at(1) == sync_second))
            begin
                rd_ptr = (rd_ptr + 1) % DEPTH;
                u--;
            end
            if (u < FRAME_OVERHEAD)
                break;
            len = at(OFS_LEN);
            if (u < len + FRAME_OVERHEAD)
                break;
            sum = 8'd0;
            for (int unsigned i = 0; i <= len + OFS_LEN; i++)
                sum ^= at(i);
            if (sum != at(len + OFS_PAYLOAD))
            begin
                rd_ptr = (rd_ptr + HEADER_SKIP) % DEPTH;
                continue;
            end
            r = '0;
            r.id = at(2);
            r.rem = at(3);
            r.command = at(4);
            r.len = len[7:0];
            if (len == 0)
            begin
                r.pend = 1'b1;
                payload_queue.push_back(r);
            end
            for (int unsigned i = 0; i < len; i++)
            begin
                r.index = i[7:0];
                r.value = at(OFS_PAYLOAD + i);
                r.has = 1'b1;
                r.pend = (i + 1 == len);
                payload_queue.push_back(r);
            end
            rd_ptr = (rd_ptr + len + FRAME_OVERHEAD) % DEPTH;
        end
        if (payload_queue.size() > first)
            payload_queue[payload_queue.size() - 1].fin = 1'b1;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        frame_result_t e;
        if (!rst_n)
        begin
            payload_queue.delete();
            wr_ptr = 0;
            rd_ptr = 0;
            sync_first = HDR_FIRST_RST;
            sync_second = HDR_SECOND_RST;
            fail_count = 0;
            result_count = 0;
            for (int i = 0; i < DEPTH; i++)
                ring[i] = 8'd0;
        end
        else
        begin
            if (psel && penable && pwrite)
            begin
                if (paddr == REG_HDR_FIRST)
                    sync_first = pwdata[7:0];
                else
                    sync_second = pwdata[7:0];
            end
            if (out_valid && !out_stall)
            begin
                result_count++;
                if (payload_queue.size() == 0)
                begin
                    report("unexpected result, data_byte", data_byte, 8'd0);
                end
                else
                begin
                    e = payload_queue.pop_front();
                    if (pkg_id !== e.id) report("pkg_id", pkg_id, e.id);
                    if (remain !== e.rem) report("remain", remain, e.rem);
                    if (cmd !== e.command) report("cmd", cmd, e.command);
                    if (data_len !== e.len) report("data_len", data_len, e.len);
                    if (data_index !== e.index) report("data_index", data_index, e.index);
                    if (data_byte !== e.value) report("data_byte", data_byte, e.value);
                    if (has_data !== e.has) report("has_data", has_data, e.has);
                    if (packet_end !== e.pend) report("packet_end", packet_end, e.pend);
                    if (last !== e.fin) report("last", last, e.fin);
                end
            end
            if (in_valid && !in_stall)
                deframe_byte(rx_byte);
        end
    end
endmodule

FILE: tb/xor_checked_packet_deframer_core_tb.sv
// Top of the deframer testbench: clock, reset, register writes and byte
// stimulus in framed, corrupted and noise form, plus the verdict.
// Depends on xcpd_pkg, the deframer core and xcpd_checker.
`timescale 1ns / 1ps
module xor_checked_packet_deframer_core_tb;
    import xcpd_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [2:2] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [7:0] rx_byte = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [7:0] pkg_id, remain, cmd, data_len, data_index, data_byte;
    logic has_data, packet_end, last;
    int fail_count, pending_count, result_count;
    int send_idle_pct = 0;
    int stall_pct = 0;
    int bytes_sent = 0;
    int frames_sent = 0;
    int quiet_cycles = 0;
    logic [7:0] sync_a = HDR_FIRST_RST;
    logic [7:0] sync_b = HDR_SECOND_RST;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    xor_checked_packet_deframer_core dut (.*);

    xcpd_checker checker_i (.*);

    always @(posedge clk)
        out_stall <= ($urandom_range(99) < stall_pct);

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("xor_checked_packet_deframer_core regression: fail");
            $finish;
        end
    end

    task automatic write_reg(logic [0:0] idx, logic [7:0] val);
        @(posedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= idx;
        pwdata <= {24'd0, val};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (idx == REG_HDR_FIRST)
            sync_a = val;
        else
            sync_b = val;
    endtask

    task automatic send_byte(logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        bytes_sent++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0 || in_stall)
            @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    // A frame of the given length; a nonzero corrupt mask spoils the checksum.
    task automatic send_frame(int len, logic [7:0] flip);
        logic [7:0] b[$];
        logic [7:0] sum;
        b = {sync_a, sync_b, 8'($urandom), 8'($urandom), 8'($urandom), 8'(len)};
        for (int i = 0; i < len; i++)
            b.push_back(8'($urandom));
        sum = 8'd0;
        foreach (b[i])
            sum ^= b[i];
        b.push_back(sum ^ flip);
        foreach (b[i])
            send_byte(b[i]);
        frames_sent++;
    endtask

    task automatic random_part(int n);
        int k;
        int start;
        start = bytes_sent;
        while (bytes_sent - start < n)
        begin
            k = $urandom_range(99);
            if (k < 60)
                send_frame(($urandom_range(9) == 0) ? $urandom_range(57) : $urandom_range(6),
                    8'h00);
            else if (k < 72)
                send_frame($urandom_range(6), 8'(1 << $urandom_range(7)));
            else if (k < 80)
                send_byte(sync_a);
            else
                send_byte(8'($urandom));
        end
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        send_frame(0, 8'h00);
        send_frame(1, 8'h00);
        send_frame(3, 8'h01);
        send_byte(8'h00);
        send_byte(8'hff);
        send_byte(sync_a);
        send_frame(40, 8'h00);
        send_frame(60, 8'h00);
        drain();
        write_reg(REG_HDR_FIRST, 8'h00);
        write_reg(REG_HDR_SECOND, 8'hff);
        send_frame(2, 8'h00);
        send_frame(0, 8'h80);
        send_frame(4, 8'h00);
        drain();
        send_idle_pct = 32;
        stall_pct = 66;
        write_reg(REG_HDR_FIRST, 8'hff);
        write_reg(REG_HDR_SECOND, 8'h00);
        random_part(18);
        drain();
        send_idle_pct = 66;
        stall_pct = 32;
        write_reg(REG_HDR_FIRST, 8'($urandom));
        write_reg(REG_HDR_SECOND, 8'($urandom));
        random_part(18);
        drain();
        send_idle_pct = 0;
        stall_pct = 0;
        write_reg(REG_HDR_FIRST, HDR_FIRST_RST);
        write_reg(REG_HDR_SECOND, HDR_SECOND_RST);
        random_part(18);
        drain();
        $display("Sent %0d bytes in %0d frames plus noise; %0d results checked.",
            bytes_sent, frames_sent, result_count);
        if (fail_count == 0)
            $display("xor_checked_packet_deframer_core regression: pass");
        else
            $display("xor_checked_packet_deframer_core regression: fail");
        $finish;
    end
endmodule
